>>> design/mrrc_pkg.sv
package mrrc_pkg;

    localparam int MAX_FRAME_DEF = 64;
    localparam int MIN_REPLY     = 9;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  FUNC_READ = 8'h03;
    localparam logic [7:0]  SLAVE_ID_RST = 8'h01;

    // input beat kinds (tuser)
    localparam logic [1:0] ACT_DATA    = 2'd0;
    localparam logic [1:0] ACT_LAST    = 2'd1;
    localparam logic [1:0] ACT_NOREPLY = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOREPLY = 3'd1;
    localparam logic [2:0] ST_SHORT   = 3'd2;
    localparam logic [2:0] ST_CRC     = 3'd3;
    localparam logic [2:0] ST_SLAVE   = 3'd4;
    localparam logic [2:0] ST_FUNC    = 3'd5;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // one classified frame event, front to back
    typedef struct packed {
        logic        noreply;
        logic        short_frame;
        logic        crc_ok;
        logic [7:0]  addr;
        logic [7:0]  func;
        logic [31:0] data;
    } t_verdict;

    // CRC-16/Modbus, one byte folded in
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> design/mrrc_front.sv
module mrrc_front #(
    parameter int MAX_FRAME = mrrc_pkg::MAX_FRAME_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat,      // accepted input beat
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_rx_byte,
    output logic               o_push,
    output mrrc_pkg::t_verdict o_verdict
);
    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_addr, n_addr;
    logic [7:0]       r_func, n_func;
    logic [31:0]      r_data, n_data;

    logic is_byte;
    logic room;
    logic frame_end;

    assign is_byte   = i_beat && (i_action == mrrc_pkg::ACT_DATA ||
                                  i_action == mrrc_pkg::ACT_LAST);
    assign room      = r_count < CNT_W'(MAX_FRAME);
    assign frame_end = i_beat && (i_action == mrrc_pkg::ACT_LAST ||
                                  i_action == mrrc_pkg::ACT_NOREPLY);

    // frame state with the current byte taken in
    always_comb begin
        n_crc   = r_crc;
        n_tail  = r_tail;
        n_count = r_count;
        n_addr  = r_addr;
        n_func  = r_func;
        n_data  = r_data;
        if (is_byte && room) begin
            if (r_count >= CNT_W'(2)) begin
                n_crc = mrrc_pkg::crc_fold(r_crc, r_tail[15:8]);
            end
            n_tail  = {r_tail[7:0], i_rx_byte};
            n_count = r_count + CNT_W'(1);
            if (r_count == CNT_W'(0)) begin
                n_addr = i_rx_byte;
            end
            if (r_count == CNT_W'(1)) begin
                n_func = i_rx_byte;
            end
            if (r_count >= CNT_W'(3) && r_count <= CNT_W'(6)) begin
                n_data = {r_data[23:0], i_rx_byte};
            end
        end
    end

    always_comb begin
        o_push                = frame_end;
        o_verdict.noreply     = (i_action == mrrc_pkg::ACT_NOREPLY);
        o_verdict.short_frame = n_count < CNT_W'(mrrc_pkg::MIN_REPLY);
        o_verdict.crc_ok      = (n_crc == {n_tail[7:0], n_tail[15:8]});
        o_verdict.addr        = n_addr;
        o_verdict.func        = n_func;
        o_verdict.data        = n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || frame_end) begin
            r_crc   <= mrrc_pkg::CRC_INIT;
            r_tail  <= '0;
            r_count <= '0;
            r_addr  <= '0;
            r_func  <= '0;
            r_data  <= '0;
        end else begin
            r_crc   <= n_crc;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_addr  <= n_addr;
            r_func  <= n_func;
            r_data  <= n_data;
        end
    end

endmodule

>>> design/mrrc_queue.sv
module mrrc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mrrc_pkg::t_verdict i_verdict,
    output logic               o_ready,
    input  logic               i_pop,
    output logic               o_valid,
    output mrrc_pkg::t_verdict o_verdict
);
    mrrc_pkg::t_verdict r_mem [mrrc_pkg::Q_DEPTH];

    logic [mrrc_pkg::Q_PTR_W-1:0] r_wptr;
    logic [mrrc_pkg::Q_PTR_W-1:0] r_rptr;
    logic [mrrc_pkg::Q_CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_ready   = r_cnt != mrrc_pkg::Q_CNT_W'(mrrc_pkg::Q_DEPTH);
    assign o_valid   = r_cnt != '0;
    assign o_verdict = r_mem[r_rptr];
    assign do_push   = i_push && o_ready;
    assign do_pop    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + mrrc_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + mrrc_pkg::Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + mrrc_pkg::Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - mrrc_pkg::Q_CNT_W'(1);
            end
        end
    end

endmodule

>>> design/mrrc_back.sv
module mrrc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_q_valid,
    input  mrrc_pkg::t_verdict i_verdict,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [15:0]        o_level,
    output logic [15:0]        o_signal,
    output logic               o_present
);
    logic [7:0]  r_slave_id;
    logic [15:0] r_cache_level, n_cache_level;
    logic [15:0] r_cache_signal, n_cache_signal;
    logic        r_valid;
    logic [2:0]  r_status, n_status;
    logic [15:0] r_level;
    logic [15:0] r_signal;
    logic        r_present;

    assign o_pop     = i_q_valid && (!r_valid || i_ready);
    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_level   = r_level;
    assign o_signal  = r_signal;
    assign o_present = r_present;

    always_comb begin
        priority if (i_verdict.noreply) begin
            n_status = mrrc_pkg::ST_NOREPLY;
        end else if (i_verdict.short_frame) begin
            n_status = mrrc_pkg::ST_SHORT;
        end else if (!i_verdict.crc_ok) begin
            n_status = mrrc_pkg::ST_CRC;
        end else if (i_verdict.addr != r_slave_id) begin
            n_status = mrrc_pkg::ST_SLAVE;
        end else if (i_verdict.func != mrrc_pkg::FUNC_READ) begin
            n_status = mrrc_pkg::ST_FUNC;
        end else begin
            n_status = mrrc_pkg::ST_OK;
        end
        n_cache_level  = r_cache_level;
        n_cache_signal = r_cache_signal;
        if (n_status == mrrc_pkg::ST_OK) begin
            n_cache_level  = i_verdict.data[31:16];
            n_cache_signal = i_verdict.data[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_id     <= mrrc_pkg::SLAVE_ID_RST;
            r_cache_level  <= '0;
            r_cache_signal <= '0;
            r_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slave_id <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_cache_level  <= n_cache_level;
                r_cache_signal <= n_cache_signal;
                r_valid        <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status  <= n_status;
            r_level   <= n_cache_level;
            r_signal  <= n_cache_signal;
            r_present <= n_cache_level != '0;
        end
    end

endmodule

>>> design/modbus_read_reply_checker_top.sv
// Channel  | Dir | Beat                      | Payload
// s_axis   | in  | one reply byte or event   | tdata: rx_byte[7:0]; tuser: action[1:0]
// m_axis   | out | one check result          | tdata: level, signal, liquid_present
// cfg      | in  | slave_id write            | i_cfg_wdata[7:0] on i_cfg_we
//
// One input beat per cycle while s_axis_tready is high. A frame-end beat is classified
// and queued at its accepting edge; the back pops it into its output register, raising
// m_axis_tvalid, once that register is empty or its beat is being taken.
// The front's byte-wide CRC update sets throughput: one byte per cycle unless stalled.
// Synchronous active-low reset clears frame state, cached values, slave_id to 1.
// s_axis_tready drops only when the queue is full: two results waiting behind an
// m_axis beat that has not yet been taken.
module modbus_read_reply_checker_top #(
    parameter int MAX_FRAME = mrrc_pkg::MAX_FRAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: expected slave address
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] level_value, [31:16] signal_value,
                                        // [32] liquid_present, [39:33] zero
    output logic [2:0]  m_axis_tuser    // [2:0] status
);
    logic               in_beat;
    logic               q_ready;
    logic               push;
    mrrc_pkg::t_verdict push_verdict;
    logic               q_valid;
    logic               pop;
    mrrc_pkg::t_verdict q_verdict;
    logic [15:0]        level;
    logic [15:0]        signal;
    logic               present;

    assign s_axis_tready = q_ready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // front: byte accumulation, CRC, frame-end classification
    mrrc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (in_beat),
        .i_action  (s_axis_tuser),
        .i_rx_byte (s_axis_tdata),
        .o_push    (push),
        .o_verdict (push_verdict)
    );

    mrrc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_verdict (push_verdict),
        .o_ready   (q_ready),
        .i_pop     (pop),
        .o_valid   (q_valid),
        .o_verdict (q_verdict)
    );

    // back: status priority, value cache, output register
    mrrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_verdict   (q_verdict),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_level     (level),
        .o_signal    (signal),
        .o_present   (present)
    );

    assign m_axis_tdata = {7'b0, present, signal, level};

endmodule
